// ===== rtl/hei_pkg.sv =====
// Types and constants shared by the hard-edge interior removal block.
package hei_pkg;

  localparam int CFG_DATA_BITS   = 16;
  localparam int CFG_WIDTH_BITS  = 11;
  localparam int CFG_HEIGHT_BITS = 16;
  localparam int CFG_BG_BITS     = 8;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT = 2'd1;
  localparam cfg_idx_t CFG_BACKGROUND   = 2'd2;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

endpackage

// ===== rtl/hard_edge_interior_removal.sv =====
// Top level of the hard-edge interior removal filter with two line-store memories.
// Throughput: one beat per cycle while out_stall is low; stage one stalls the input.
// The result of pixel k is formed from the beat that carries item k + width + 1: it is
// registered in stage one (line-store read), then in the output register (window and compare).
// Reset clears counters, window and configuration; the line stores are not cleared
// and there is no clearing pass.
module hard_edge_interior_removal #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  hei_pkg::cfg_idx_t                  cfg_index,
  input  logic [hei_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  hei_pkg::cmd_t                      command,
  input  logic [PIXEL_BITS-1:0]              pixel_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [PIXEL_BITS-1:0]              pixel_out,
  output logic                               line_end,
  output logic                               frame_end
);
  import hei_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (CW > CFG_WIDTH_BITS) ? CW : CFG_WIDTH_BITS;
  localparam int RW   = CFG_HEIGHT_BITS + 1;

  logic [CFG_WIDTH_BITS-1:0]  cfg_width;
  logic [CFG_HEIGHT_BITS-1:0] cfg_height;
  logic [CFG_BG_BITS-1:0]     cfg_bg;

  logic [CMPW-1:0]            width_x;
  logic [CW-1:0]              w_eff;
  logic [CW-1:0]              w_m1;
  logic [CFG_HEIGHT_BITS-1:0] h_eff;
  logic [CFG_HEIGHT_BITS-1:0] h_m1;
  logic [PIXEL_BITS-1:0]      bg_px;
  logic                       geom_write;

  logic [AW-1:0]              in_column;
  logic [AW-1:0]              in_column_next;
  logic [RW-1:0]              in_row;
  logic [RW-1:0]              in_row_next;
  logic [AW-1:0]              out_column;
  logic [AW-1:0]              out_column_next;
  logic [CFG_HEIGHT_BITS-1:0] out_row;
  logic [CFG_HEIGHT_BITS-1:0] out_row_next;

  logic                       accept;
  logic                       in_frame;
  logic                       noop;
  logic                       take;
  logic                       gives_result;
  logic                       col_last;
  logic                       row_last;
  logic                       fr_last;
  logic [PIXEL_BITS-1:0]      take_pix;

  logic [PIXEL_BITS-1:0]      upper_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0]      middle_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0]      upper_q;
  logic [PIXEL_BITS-1:0]      middle_q;

  logic                       s1_valid;
  logic                       s1_res;
  logic                       s1_adv;
  logic [AW-1:0]              s1_col;
  logic [PIXEL_BITS-1:0]      s1_pix;
  border_t                    s1_border;
  logic                       s1_frame_end;
  logic                       s1_hit;
  logic [PIXEL_BITS-1:0]      s1_fwd_upper;
  logic [PIXEL_BITS-1:0]      s1_fwd_middle;
  logic [PIXEL_BITS-1:0]      s1_a;
  logic [PIXEL_BITS-1:0]      s1_b;

  logic [PIXEL_BITS-1:0]      win [3][3];
  logic [PIXEL_BITS-1:0]      win_next [3][3];
  logic [PIXEL_BITS-1:0]      center;
  logic                       interior;

  // Configuration registers and effective geometry.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= CFG_WIDTH_BITS'(1024);
      cfg_height <= CFG_HEIGHT_BITS'(1);
      cfg_bg     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg_width  <= cfg_data[CFG_WIDTH_BITS-1:0];
        CFG_IMAGE_HEIGHT: cfg_height <= cfg_data[CFG_HEIGHT_BITS-1:0];
        CFG_BACKGROUND:   cfg_bg     <= cfg_data[CFG_BG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    width_x = CMPW'(cfg_width);
    if (width_x == '0) begin
      w_eff = CW'(1);
    end else if (width_x > CMPW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_x);
    end
    w_m1  = w_eff - CW'(1);
    h_eff = (cfg_height == '0) ? CFG_HEIGHT_BITS'(1) : cfg_height;
    h_m1  = h_eff - CFG_HEIGHT_BITS'(1);
    bg_px = PIXEL_BITS'(cfg_bg);
    geom_write = cfg_write &&
                 (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);
  end

  // Input side: position bookkeeping for each accepted beat that is not an in-frame flush.
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_frame     = in_row < {1'b0, h_eff};
    noop         = in_frame && (command == CMD_FLUSH);
    take         = accept && !noop;
    take_pix     = in_frame ? pixel_in : '0;
    gives_result = !((in_row == '0) || ((in_row == RW'(1)) && (in_column == '0)));
    col_last     = CW'(out_column) == w_m1;
    row_last     = out_row == h_m1;
    fr_last      = col_last && row_last;

    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (geom_write) begin
      in_column_next  = '0;
      in_row_next     = '0;
      out_column_next = '0;
      out_row_next    = '0;
    end else if (take) begin
      if (CW'(in_column) == w_m1) begin
        in_column_next = '0;
        in_row_next    = in_row + RW'(1);
      end else begin
        in_column_next = in_column + AW'(1);
      end
      if (gives_result) begin
        if (fr_last) begin
          in_column_next  = '0;
          in_row_next     = '0;
          out_column_next = '0;
          out_row_next    = '0;
        end else if (col_last) begin
          out_column_next = '0;
          out_row_next    = out_row + CFG_HEIGHT_BITS'(1);
        end else begin
          out_column_next = out_column + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  // Line stores: read at acceptance, written back when the beat leaves stage one.
  always_ff @(posedge clk) begin
    if (take) begin
      upper_q <= upper_mem[in_column];
    end
    if (s1_adv) begin
      upper_mem[s1_col] <= s1_b;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      middle_q <= middle_mem[in_column];
    end
    if (s1_adv) begin
      middle_mem[s1_col] <= s1_pix;
    end
  end

  // Stage one control.
  assign s1_adv = s1_valid && (!s1_res || !out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_res           <= gives_result;
      s1_col           <= in_column;
      s1_pix           <= take_pix;
      s1_border.top    <= out_row == '0;
      s1_border.bottom <= row_last;
      s1_border.left   <= out_column == '0;
      s1_border.right  <= col_last;
      s1_frame_end     <= fr_last;
      s1_hit           <= s1_adv && (s1_col == in_column);
      s1_fwd_upper     <= s1_b;
      s1_fwd_middle    <= s1_pix;
    end
  end

  // Window shift and the neighborhood compare.
  always_comb begin
    s1_a = s1_hit ? s1_fwd_upper : upper_q;
    s1_b = s1_hit ? s1_fwd_middle : middle_q;
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
    end
    win_next[0][2] = s1_a;
    win_next[1][2] = s1_b;
    win_next[2][2] = s1_pix;

    center   = win_next[1][1];
    interior = center != bg_px;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!((r == 1) && (c == 1)) &&
            !((r == 0) && s1_border.top) && !((r == 2) && s1_border.bottom) &&
            !((c == 0) && s1_border.left) && !((c == 2) && s1_border.right) &&
            (win_next[r][c] != center)) begin
          interior = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (s1_adv) begin
      win <= win_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_res) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_res) begin
      pixel_out <= interior ? bg_px : center;
      line_end  <= s1_border.right;
      frame_end <= s1_frame_end;
    end
  end

endmodule

// ===== verif/hard_edge_interior_removal_test.sv =====
// Self-checking testbench for the hard-edge interior removal filter with its own pixel predictor.
`timescale 1ns / 100ps

module hard_edge_interior_removal_test;
  import hei_pkg::*;

  localparam int MAX_WIDTH      = 1024;
  localparam int PIXEL_BITS     = 8;
  localparam cfg_idx_t CFG_SPARE = 2'd3;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_GAP        = 64;
  localparam int REPORT_LIMIT   = 10;
  localparam int FULL_FRAME     = 32'h7FFF_FFFF;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  typedef struct packed {
    pixel_t value;
    logic   line_end;
    logic   frame_end;
  } filtered_pixel_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  cfg_idx_t                 cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  cmd_t                     command = CMD_PIXEL;
  pixel_t                   pixel_in = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  pixel_t                   pixel_out;
  logic                     line_end;
  logic                     frame_end;

  hard_edge_interior_removal #(
    .MAX_WIDTH(MAX_WIDTH),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .pixel_in(pixel_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_out(pixel_out),
    .line_end(line_end),
    .frame_end(frame_end)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  pixel_t                    upper_row [MAX_WIDTH];
  pixel_t                    middle_row [MAX_WIDTH];
  pixel_t                    window [3][3];
  longint                    next_in_col, next_in_row, next_out_col, next_out_row;
  logic [CFG_WIDTH_BITS-1:0]  width_reg;
  logic [CFG_HEIGHT_BITS-1:0] height_reg;
  pixel_t                    background;
  filtered_pixel_t           expected_pixels [$];
  bit                        frame_closed;
  int                        live_beats;

  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_token;
  int     hold_seen;
  int     hold_left;
  int     mismatches;
  int     results_seen;
  int     quiet_cycles;
  filtered_pixel_t wanted;

  bit     raw_pattern;
  int     blk_rows, blk_cols, noise_pct;
  pixel_t shade_a, shade_b;

  function automatic longint active_width();
    if (width_reg == '0) return longint'(1);
    if (width_reg > MAX_WIDTH) return longint'(MAX_WIDTH);
    return longint'(width_reg);
  endfunction

  function automatic longint active_height();
    return (height_reg == '0) ? longint'(1) : longint'(height_reg);
  endfunction

  function automatic void restart_counters();
    next_in_col  = 0;
    next_in_row  = 0;
    next_out_col = 0;
    next_out_row = 0;
  endfunction

  function automatic void clear_predictor();
    int i, j;
    for (i = 0; i < MAX_WIDTH; i++) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) window[i][j] = '0;
    end
    restart_counters();
    width_reg    = 11'd1024;
    height_reg   = 16'd1;
    background   = '0;
    frame_closed = 1'b0;
  endfunction

  function automatic void predict_beat(cmd_t cmd, pixel_t pix);
    longint w, h, total, pos, out_pos, nr, nc;
    int r, dr, dc;
    pixel_t v, above, mid, center;
    bit interior;
    filtered_pixel_t res;
    w = active_width();
    h = active_height();
    total = w * h;
    pos = next_in_row * w + next_in_col;
    v = '0;
    if (pos < total) begin
      if (cmd == CMD_FLUSH) return;
      v = pix;
      if (pos == 0) frame_closed = 1'b0;
    end
    live_beats++;
    above = upper_row[next_in_col];
    mid   = middle_row[next_in_col];
    upper_row[next_in_col]  = mid;
    middle_row[next_in_col] = v;
    for (r = 0; r < 3; r++) begin
      window[r][0] = window[r][1];
      window[r][1] = window[r][2];
    end
    window[0][2] = above;
    window[1][2] = mid;
    window[2][2] = v;
    next_in_col++;
    if (next_in_col >= w) begin
      next_in_col = 0;
      next_in_row++;
    end
    if (pos < w + 1) return;
    center = window[1][1];
    interior = (center != background);
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        nr = next_out_row + dr;
        nc = next_out_col + dc;
        if ((dr != 0 || dc != 0) && nr >= 0 && nr < h && nc >= 0 && nc < w &&
            window[dr+1][dc+1] != center) interior = 1'b0;
      end
    end
    out_pos = next_out_row * w + next_out_col;
    res.value     = interior ? background : center;
    res.line_end  = (next_out_col == w - 1);
    res.frame_end = (out_pos + 1 == total);
    expected_pixels.push_back(res);
    if (out_pos + 1 >= total) begin
      restart_counters();
      frame_closed = 1'b1;
    end else begin
      next_out_col++;
      if (next_out_col >= w) begin
        next_out_col = 0;
        next_out_row++;
      end
    end
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH: begin
        width_reg = data[CFG_WIDTH_BITS-1:0];
        restart_counters();
      end
      CFG_IMAGE_HEIGHT: begin
        height_reg = data[CFG_HEIGHT_BITS-1:0];
        restart_counters();
      end
      CFG_BACKGROUND: background = data[CFG_BG_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_geometry(logic [CFG_DATA_BITS-1:0] w, logic [CFG_DATA_BITS-1:0] h);
    write_register(CFG_IMAGE_WIDTH, w);
    write_register(CFG_IMAGE_HEIGHT, h);
  endtask

  task automatic send_beat(cmd_t cmd, pixel_t pix);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    pixel_in <= pix;
    do @(posedge clk); while (in_stall);
    predict_beat(cmd, pix);
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] random_background();
    logic [CFG_BG_BITS-1:0] bg;
    case ($urandom_range(5))
      0: bg = '0;
      1: bg = '1;
      default: bg = CFG_BG_BITS'($urandom_range(255));
    endcase
    return {8'($urandom_range(255)), bg};
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] random_width();
    logic [CFG_WIDTH_BITS-1:0] w;
    case ($urandom_range(19))
      0: w = 11'd0;
      1: w = 11'd1;
      2, 3: w = CFG_WIDTH_BITS'($urandom_range(40, 13));
      default: w = CFG_WIDTH_BITS'($urandom_range(12, 2));
    endcase
    return {5'($urandom_range(31)), w};
  endfunction

  function automatic void new_pattern();
    raw_pattern = ($urandom_range(6) == 0);
    blk_rows    = $urandom_range(4, 1);
    blk_cols    = $urandom_range(6, 1);
    noise_pct   = $urandom_range(5);
    shade_a     = ($urandom_range(2) == 0) ? background : pixel_t'($urandom_range(255));
    shade_b     = pixel_t'($urandom_range(255));
  endfunction

  function automatic pixel_t pattern_pixel(longint row, longint col);
    if (raw_pattern || $urandom_range(99) < noise_pct) return pixel_t'($urandom_range(255));
    return (((row / blk_rows) + (col / blk_cols)) % 2) ? shade_b : shade_a;
  endfunction

  // Late pixels during the drain act as flush beats and must not disturb the frame.
  task automatic close_frame(bit noisy);
    while (!frame_closed) begin
      if (noisy && $urandom_range(99) < 20) send_beat(CMD_PIXEL, pixel_t'($urandom_range(255)));
      else send_beat(CMD_FLUSH, pixel_t'($urandom_range(255)));
    end
  endtask

  task automatic send_frame(longint stop_at, longint bg_at, bit noisy);
    longint w, total, k;
    w = active_width();
    total = w * active_height();
    new_pattern();
    for (k = 0; k < total && k < stop_at; k++) begin
      if (k == bg_at) write_register(CFG_BACKGROUND, random_background());
      if (noisy && $urandom_range(99) < 4) send_beat(CMD_FLUSH, pixel_t'($urandom_range(255)));
      send_beat(CMD_PIXEL, pattern_pixel(k / w, k % w));
    end
    if (k < total) return;
    close_frame(noisy);
  endtask

  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_geometry(16'd3, 16'd3);
    write_register(CFG_BACKGROUND, 16'd0);
    send_beat(CMD_FLUSH, 8'hFF);
    send_beat(CMD_PIXEL, 8'h00);
    repeat (8) send_beat(CMD_PIXEL, 8'hFF);
    send_beat(CMD_PIXEL, 8'h4D);
    close_frame(1'b0);
    write_register(CFG_SPARE, 16'hFFFF);
    write_register(CFG_BACKGROUND, 16'hFFFF);
    set_geometry(16'd0, 16'd0);
    send_beat(CMD_PIXEL, 8'hFF);
    close_frame(1'b0);
    send_beat(CMD_PIXEL, 8'h80);
    close_frame(1'b0);
  endtask

  task automatic test_geometry_extremes();
    send_idle_pct  = 0;
    recv_stall_pct = 10;
    set_geometry(16'h07FF, 16'd2);
    write_register(CFG_BACKGROUND, 16'h005A);
    send_frame(1030, -1, 1'b0);
    set_geometry(16'd3, 16'hFFFF);
    send_frame(60, -1, 1'b1);
    set_geometry(16'd1, 16'd5);
    send_frame(FULL_FRAME, -1, 1'b0);
  endtask

  task automatic test_output_hold();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_geometry(16'd8, 16'd6);
    write_register(CFG_BACKGROUND, random_background());
    hold_token++;
    send_frame(FULL_FRAME, -1, 1'b0);
    drain_results();
    recv_stall_pct = 30;
    hold_token++;
    send_frame(FULL_FRAME, -1, 1'b1);
    drain_results();
  endtask

  task automatic test_random_frames(int send_pct, int stall_pct, int beats);
    int target, frames, f;
    longint total, stop_at, bg_at;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    target = live_beats + beats;
    while (live_beats < target) begin
      write_register(CFG_IMAGE_WIDTH, random_width());
      write_register(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'($urandom_range(8)));
      write_register(CFG_BACKGROUND, random_background());
      frames = $urandom_range(3, 1);
      for (f = 0; f < frames; f++) begin
        total   = active_width() * active_height();
        stop_at = ($urandom_range(9) == 0) ? longint'($urandom_range(32'(total))) :
                                             longint'(FULL_FRAME);
        bg_at   = ($urandom_range(6) == 0) ? longint'($urandom_range(32'(total - 1))) :
                                             longint'(-1);
        send_frame(stop_at, bg_at, $urandom_range(3) != 0);
        if (!frame_closed) break;
      end
    end
    drain_results();
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected beat %0d: pixel %0d line_end %b frame_end %b",
                     results_seen, pixel_out, line_end, frame_end);
        end else begin
          wanted = expected_pixels.pop_front();
          if (pixel_out !== wanted.value || line_end !== wanted.line_end ||
              frame_end !== wanted.frame_end) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("beat %0d: expected pixel %0d line_end %b frame_end %b, got %0d %b %b",
                       results_seen, wanted.value, wanted.line_end, wanted.frame_end,
                       pixel_out, line_end, frame_end);
          end
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    clear_predictor();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_geometry_extremes();
    test_output_hold();
    test_random_frames(0, 0, 60);
    test_random_frames(88, 0, 60);
    test_random_frames(0, 88, 60);
    test_random_frames(14, 14, 60);
    recv_stall_pct = 0;
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
